// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/des_ofb_pkg.sv -----
package des_ofb_pkg;

   localparam int DataWidth = 64;

   typedef enum logic [1:0] {
      CSR_KEY  = 2'd0,
      CSR_IV   = 2'd1,
      CSR_MODE = 2'd2
   } csr_index_type;

   typedef logic [1:0] csr_addr_type;

   typedef struct packed {
      logic [DataWidth-1:0] data_in;
      logic                 last_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [DataWidth-1:0] data_out;
      logic                 last_out;
   } rsp_payload_type;

   localparam logic [7:0] TabIp [64] = '{
      58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
   localparam logic [7:0] TabFp [64] = '{
      40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
   localparam logic [7:0] TabE [48] = '{
      32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
      16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
   localparam logic [7:0] TabP [32] = '{
      16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
   localparam logic [7:0] TabPc1 [56] = '{
      57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
      60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
      29,21,13,5,28,20,12,4};
   localparam logic [7:0] TabPc2 [48] = '{
      14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
      41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
   localparam logic [1:0] TabRot [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
   localparam logic [3:0] TabS [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   // Bit positions count from 1 at the most significant bit.
   function automatic logic [63:0] perm_ip(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabIp[i])];
      return r;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(TabFp[i])];
      return r;
   endfunction

   function automatic logic [55:0] perm_pc1(input logic [63:0] v);
      logic [55:0] r;
      for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(TabPc1[i])];
      return r;
   endfunction

   function automatic logic [47:0] perm_pc2(input logic [55:0] v);
      logic [47:0] r;
      for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(TabPc2[i])];
      return r;
   endfunction

   function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] s);
      return (s == 2'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
   endfunction

   function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0]  six;
      for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(TabE[i])];
      x = x ^ k;
      for (int i = 0; i < 8; i++) begin
         six = x[47-6*i -: 6];
         s[31-4*i -: 4] = TabS[i][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TabP[i])];
      return p;
   endfunction

endpackage

// ----- rtl/des_ofb_stream_cipher_top.sv -----
// DES output-feedback stream cipher (8-bit or 64-bit OFB).
// Request channel (req_*): data_in and last_of_message; one response per request.
// Response channel (rsp_*): data_out (data XOR keystream) and last_out.
// CSR channel (csr_*): index 0 key, 1 IV, 2 feedback mode; other indexes dropped.
//   Write CSRs only while no request is in flight; csr_ready is always high.
// The response is registered: a request accepted at a clock edge has its response valid right after that edge.
// Throughput: one request per cycle while the response is not held. The 16
//   DES rounds sit fully unrolled between the feedback register and the
//   response register, since each keystream block depends on the previous one.
// Stall: the response register holds while rsp_ready is low; req_ready
//   follows rsp_ready so the response slot is freed as a new one loads.
// Reset (synchronous, active high): clears CSRs, feedback register, marks
//   the next request as a message start (IV load) and empties the response.
// A request with last_of_message set makes the next request restart from IV.
module des_ofb_stream_cipher_top
   import des_ofb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  csr_addr_type    csr_index,
   input  logic [63:0]     csr_wdata
);
`include "assert_macros.svh"

   logic [63:0]     key_ff, iv_ff, fb_ff, fb_in;
   logic            mode_ff, fresh_ff, rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;
   logic            req_fire;

   logic [63:0] blk, ks, v;
   logic [55:0] cd;
   logic [27:0] c, d;
   logic [31:0] l, r, t;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Keystream: unrolled DES encryption of the feedback value.
   always_comb begin
      blk = fresh_ff ? iv_ff : fb_ff;
      cd  = perm_pc1(key_ff);
      c   = cd[55:28];
      d   = cd[27:0];
      v   = perm_ip(blk);
      l   = v[63:32];
      r   = v[31:0];
      for (int i = 0; i < 16; i++) begin
         c = rot28(c, TabRot[i]);
         d = rot28(d, TabRot[i]);
         t = l ^ round_f(r, perm_pc2({c, d}));
         l = r;
         r = t;
      end
      ks = perm_fp({r, l});
      if (mode_ff) begin
         rsp_in.data_out = req_payload.data_in ^ ks;
         fb_in = ks;
      end else begin
         rsp_in.data_out = {56'd0, req_payload.data_in[7:0] ^ ks[63:56]};
         fb_in = {blk[55:0], ks[63:56]};
      end
      rsp_in.last_out = req_payload.last_of_message;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         iv_ff        <= '0;
         mode_ff      <= 1'b0;
         fb_ff        <= '0;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_KEY:  key_ff  <= csr_wdata;
               CSR_IV:   iv_ff   <= csr_wdata;
               CSR_MODE: mode_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         // Advance the feedback chain on every accepted request.
         if (req_fire) begin
            fb_ff    <= fb_in;
            fresh_ff <= req_payload.last_of_message;
         end
         if (req_ready) rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) rsp_ff <= rsp_in;
   end

   `ASSERT_NEXT(a_fire_gives_rsp, clock, reset, req_fire, rsp_valid,
      "accepted request produced no response")
   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload), "stalled response changed")
   `ASSERT_IMPLY(a_byte_mode_zero, clock, reset, rsp_valid && !mode_ff && $past(req_fire)
      && !$past(mode_ff) && !$past(csr_valid), rsp_payload.data_out[63:8] == 56'd0,
      "upper bits set in 8-bit mode")

endmodule

// ----- bench/des_ofb_keystream_checker.sv -----
module des_ofb_keystream_checker
   import des_ofb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  csr_addr_type    csr_index,
   input  logic [63:0]     csr_wdata,
   output int              error_count,
   output int              pending_count,
   output int              checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [63:0]     des_key;
   logic [63:0]     start_vector;
   logic            block_mode;
   logic [63:0]     shift_reg;
   logic            at_message_start;
   rsp_payload_type expected_rsp_q[$];
   int              mismatches;
   int              responses_seen;

   assign error_count   = mismatches;
   assign checked_count = responses_seen;

   // Plain DES encryption of one block, bit 1 of each table is the MSB.
   function automatic logic [63:0] des_encrypt_block(input logic [63:0] blk,
                                                     input logic [63:0] key);
      logic [55:0] cd;
      logic [55:0] cd_join;
      logic [27:0] c;
      logic [27:0] d;
      logic [63:0] v;
      logic [63:0] pre;
      logic [63:0] res;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] t;
      logic [31:0] s;
      logic [31:0] f;
      logic [47:0] k;
      logic [47:0] x;
      logic [5:0]  six;
      int          sh;
      for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(TabPc1[i])];
      c = cd[55:28];
      d = cd[27:0];
      for (int i = 0; i < 64; i++) v[63-i] = blk[64-int'(TabIp[i])];
      l = v[63:32];
      r = v[31:0];
      for (int rnd = 0; rnd < 16; rnd++) begin
         sh = int'(TabRot[rnd]);
         c = (c << sh) | (c >> (28 - sh));
         d = (d << sh) | (d >> (28 - sh));
         cd_join = {c, d};
         for (int i = 0; i < 48; i++) k[47-i] = cd_join[56-int'(TabPc2[i])];
         for (int i = 0; i < 48; i++) x[47-i] = r[32-int'(TabE[i])];
         x = x ^ k;
         for (int j = 0; j < 8; j++) begin
            six = x[47-6*j -: 6];
            s[31-4*j -: 4] = TabS[j][{six[5], six[0], six[4:1]}];
         end
         for (int i = 0; i < 32; i++) f[31-i] = s[32-int'(TabP[i])];
         t = l ^ f;
         l = r;
         r = t;
      end
      pre = {r, l};
      for (int i = 0; i < 64; i++) res[63-i] = pre[64-int'(TabFp[i])];
      return res;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      logic [63:0]     ks;
      rsp_payload_type want;
      if (reset) begin
         des_key          = '0;
         start_vector     = '0;
         block_mode       = 1'b0;
         shift_reg        = '0;
         at_message_start = 1'b1;
         expected_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY:  des_key      = csr_wdata;
               CSR_IV:   start_vector = csr_wdata;
               CSR_MODE: block_mode   = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (at_message_start) shift_reg = start_vector;
            ks = des_encrypt_block(shift_reg, des_key);
            if (block_mode) begin
               want.data_out = req_payload.data_in ^ ks;
               shift_reg     = ks;
            end else begin
               want.data_out = {56'd0, req_payload.data_in[7:0] ^ ks[63:56]};
               shift_reg     = {shift_reg[55:0], ks[63:56]};
            end
            want.last_out    = req_payload.last_of_message;
            at_message_start = req_payload.last_of_message;
            expected_rsp_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (expected_rsp_q.size() == 0) begin
               note_mismatch("unexpected response data_out", '0, rsp_payload.data_out);
            end else begin
               want = expected_rsp_q.pop_front();
               if (want.data_out !== rsp_payload.data_out)
                  note_mismatch("data_out", want.data_out, rsp_payload.data_out);
               if (want.last_out !== rsp_payload.last_out)
                  note_mismatch("last_out", 64'(want.last_out), 64'(rsp_payload.last_out));
            end
         end
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

// ----- bench/des_ofb_stream_cipher_top_tb.sv -----
module des_ofb_stream_cipher_top_tb;
   import des_ofb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Index 3 has no register behind it; writes there must be dropped.
   localparam csr_addr_type CsrUnmapped = 2'd3;
   localparam int           IdleLimit   = 5000;
   localparam logic [63:0]  AllOnes     = '1;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   csr_addr_type    csr_index;
   logic [63:0]     csr_wdata;

   int error_count;
   int pending_count;
   int checked_count;
   int sent_count;
   int setting_count;
   int idle_cycles;
   int stall_left;
   bit steady;

   des_ofb_stream_cipher_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   des_ofb_keystream_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // 8 ns clock.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Back-pressure on the response side: random stall runs, none in steady phases.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog: count cycles with no handshake on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("watchdog: no handshake for %0d cycles", idle_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request after an optional gap and hold it until accepted.
   // Valid stays high on return so back-to-back requests need no bubble.
   task automatic send_request(input logic [63:0] data, input logic last);
      int gap;
      gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid                   <= 1'b1;
      req_payload.data_in         <= data;
      req_payload.last_of_message <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Drop valid, let every response come back, then idle before the next setting.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write one register; the block must be idle.
   task automatic write_csr(input csr_addr_type idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_request(rand_word(), i == len - 1);
   endtask

   initial begin
      int          msg_len;
      int          phase_sent;
      logic [63:0] key_val;
      logic [63:0] iv_val;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_KEY;
      csr_wdata   = '0;
      sent_count  = 0;
      steady      = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset values first, zero key and zero IV.
      setting_count = 1;
      send_request('0, 1'b0);
      send_request(AllOnes, 1'b1);
      drain();

      // All-ones key, zero IV, 64-bit feedback: extremes of data.
      write_csr(CSR_KEY, AllOnes);
      write_csr(CSR_IV, '0);
      write_csr(CSR_MODE, 64'd1);
      setting_count++;
      send_request('0, 1'b0);
      send_request(AllOnes, 1'b0);
      send_request(64'h8000_0000_0000_0001, 1'b1);
      send_request(64'h0123_4567_89ab_cdef, 1'b1);
      drain();

      // Zero key, all-ones IV, 8-bit feedback; upper data bits must be ignored.
      write_csr(CSR_KEY, '0);
      write_csr(CSR_IV, AllOnes);
      write_csr(CSR_MODE, '0);
      setting_count++;
      send_request(64'hffff_ffff_ffff_ff00, 1'b0);
      send_request(64'h0000_0000_0000_00ff, 1'b0);
      send_request(64'h5a5a_5a5a_5a5a_5a5a, 1'b0);
      drain();

      // Switch to block mode in the middle of a message: no IV reload.
      write_csr(CSR_MODE, 64'd1);
      setting_count++;
      send_request(rand_word(), 1'b0);
      drain();

      // New IV and key mid-message: key applies now, IV only at the next start.
      write_csr(CSR_IV, 64'h0f1e_2d3c_4b5a_6978);
      write_csr(CSR_KEY, 64'h1334_5779_9bbc_dff1);
      setting_count++;
      send_request(rand_word(), 1'b1);
      send_request(rand_word(), 1'b0);
      drain();

      // Unmapped index must leave the key untouched; back to byte mode.
      write_csr(CsrUnmapped, AllOnes);
      write_csr(CSR_MODE, '0);
      setting_count++;
      send_request(rand_word(), 1'b1);
      send_request(rand_word(), 1'b0);
      send_request(rand_word(), 1'b1);
      drain();

      // Random: ten phases, each under its own setting.
      for (int ph = 0; ph < 10; ph++) begin
         steady  = (ph == 3 || ph == 7);
         key_val = (ph == 0) ? '0 : (ph == 1) ? AllOnes : rand_word();
         iv_val  = (ph == 1) ? '0 : (ph == 2) ? AllOnes : rand_word();
         if (ph < 3 || $urandom_range(0, 2) != 0) write_csr(CSR_KEY, key_val);
         if (ph < 3 || $urandom_range(0, 2) != 0) write_csr(CSR_IV, iv_val);
         write_csr(CSR_MODE, (ph < 2) ? 64'(ph) : {rand_word()});
         if ($urandom_range(0, 3) == 0) write_csr(CsrUnmapped, rand_word());
         setting_count++;
         phase_sent = 0;
         while (phase_sent < 100) begin
            msg_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                 : $urandom_range(9, 40);
            send_message(msg_len);
            phase_sent += msg_len;
         end
         drain();
      end
      steady = 1'b0;

      $display("Sent %0d requests across %0d settings of key, IV and feedback width;",
               sent_count, setting_count);
      $display("checked %0d responses under random gaps and response stalls.",
               checked_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
